// File: design/rbb_pkg.sv
// ----------------------------------------------------------------------------
// rbb_pkg: shared types and constants for the RGB 5x5 box blur
// Pixel and channel widths, register codes and reset values, the
// per-result metadata and the output queue entry.
// ----------------------------------------------------------------------------
package rbb_pkg;

    localparam int CHAN_W     = 8;
    localparam int NUM_LANES  = 3;
    localparam int PIX_W      = CHAN_W * NUM_LANES;
    localparam int COORD_W    = 11;
    localparam int SIZE_W     = 12;
    localparam int RECIP_W    = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // Output queue: covers every transaction inside the pipeline plus slack.
    localparam int OUT_DEPTH  = 8;
    localparam int OCC_W      = $clog2(OUT_DEPTH + 1);

    localparam logic [SIZE_W-1:0]  ROW_LIMIT     = 12'd2048;
    localparam logic [SIZE_W-1:0]  WIDTH_RESET   = 12'd640;
    localparam logic [SIZE_W-1:0]  HEIGHT_RESET  = 12'd480;
    localparam logic [RECIP_W-1:0] RECIP_RESET   = 16'd2621;
    localparam logic [CHAN_W-1:0]  CHAN_MAX      = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_RECIP_SCALE  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic               emit;
        logic [COORD_W-1:0] center_row;
        logic [COORD_W-1:0] center_col;
        logic               frame_done;
    } meta_t;

    typedef struct packed {
        logic [CHAN_W-1:0]  blur_blue;
        logic [CHAN_W-1:0]  blur_green;
        logic [CHAN_W-1:0]  blur_red;
        logic [COORD_W-1:0] center_row;
        logic [COORD_W-1:0] center_col;
        logic               frame_done;
    } result_t;

endpackage

// File: design/rbb_line_store.sv
// ----------------------------------------------------------------------------
// rbb_line_store: line memory for the earlier image rows
// One word per column holds all stored rows; one write and one registered
// read per cycle.
// ----------------------------------------------------------------------------
module rbb_line_store #(
    parameter int WORD_W = 96,
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/rbb_lane.sv
// ----------------------------------------------------------------------------
// rbb_lane: one color channel of the blur
// Column sum, window of column sums, window total, reciprocal scaling and
// saturation to the channel range.
// ----------------------------------------------------------------------------
module rbb_lane
    import rbb_pkg::*;
#(
    parameter int WINDOW = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          shift_en,
    input  logic [WINDOW-1:0][CHAN_W-1:0] col_pix,
    input  logic [RECIP_W-1:0]            recip,
    output logic [CHAN_W-1:0]             blur
);

    localparam int CSW  = $clog2(WINDOW * 255 + 1);
    localparam int SW   = $clog2(WINDOW * WINDOW * 255 + 1);
    localparam int PRW  = SW + RECIP_W;

    logic [CSW-1:0]             col_sum;
    logic [WINDOW-1:0][CSW-1:0] colsum_reg;
    logic [WINDOW-1:0][CSW-1:0] colsum_next;
    logic [SW-1:0]              win_sum;
    logic [SW-1:0]              wsum_reg;
    logic [PRW-1:0]             prod_reg;
    logic [PRW-1:0]             prod_next;
    logic [SW-1:0]              quot;

    always_comb
    begin
        col_sum = '0;
        for (int r = 0; r < WINDOW; r++)
        begin
            col_sum = col_sum + CSW'(col_pix[r]);
        end
    end

    // advance the window by one column, newest column at the top index
    always_comb
    begin
        for (int k = 0; k < WINDOW - 1; k++)
        begin
            colsum_next[k] = colsum_reg[k + 1];
        end
        colsum_next[WINDOW - 1] = col_sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colsum_reg <= '0;
        end
        else if (shift_en)
        begin
            colsum_reg <= colsum_next;
        end
    end

    always_comb
    begin
        win_sum = '0;
        for (int k = 0; k < WINDOW; k++)
        begin
            win_sum = win_sum + SW'(colsum_reg[k]);
        end
    end

    assign prod_next = PRW'(wsum_reg) * PRW'(recip);

    always_ff @(posedge clk)
    begin
        wsum_reg <= win_sum;
        prod_reg <= prod_next;
    end

    assign quot = prod_reg[PRW-1:RECIP_W];
    assign blur = (quot > SW'(CHAN_MAX)) ? CHAN_MAX : quot[CHAN_W-1:0];

endmodule

// File: design/rbb_out_fifo.sv
// ----------------------------------------------------------------------------
// rbb_out_fifo: result queue in front of the output channel
// Small register queue; the head is the presented transaction.
// ----------------------------------------------------------------------------
module rbb_out_fifo
    import rbb_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    input  logic    pop,
    output logic    head_valid,
    output result_t head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            entry [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry[wr_ptr_reg] <= push_data;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_data  = entry[rd_ptr_reg];

endmodule

// File: design/rgb_box_blur_5x5.sv
// Registered path: stage 1, column sums, window sum, product, then the queue.
// Throughput: one pixel per clock unless stalled; the line memory does one read
// and one write per pixel and the lane pipeline takes a new column every cycle.
// Input stalls only when in-flight pixels plus queued results reach eight.
// Reset: raster counters zero, window column sums zero, registers to 640x480 and
// scale 2621; the line memory is not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
// rgb_box_blur_5x5: streaming RGB box blur over a square window
// Raster-order pixels feed a line memory and three channel lanes (blue,
// green, red); a merge stage joins the lane outputs with the centre
// coordinates and queues the result.
// ----------------------------------------------------------------------------
module rgb_box_blur_5x5
    import rbb_pkg::*;
#(
    parameter int MAX_WIDTH = 2048,
    parameter int WINDOW    = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,

    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    // input pixel channel
    input  logic                  pix_valid,
    output logic                  pix_stall,
    input  logic [CHAN_W-1:0]     blue,
    input  logic [CHAN_W-1:0]     green,
    input  logic [CHAN_W-1:0]     red,

    // blurred pixel channel
    output logic                  blur_valid,
    input  logic                  blur_stall,
    output logic [CHAN_W-1:0]     blur_blue,
    output logic [CHAN_W-1:0]     blur_green,
    output logic [CHAN_W-1:0]     blur_red,
    output logic [COORD_W-1:0]    center_row,
    output logic [COORD_W-1:0]    center_col,
    output logic                  frame_done
);

    localparam int LINES  = WINDOW - 1;
    localparam int HALF   = (WINDOW - 1) / 2;
    localparam int AW     = $clog2(MAX_WIDTH);
    localparam int WCW    = $clog2(MAX_WIDTH + 1);
    localparam int EW     = (WCW > SIZE_W) ? WCW : SIZE_W;
    localparam int WORD_W = LINES * PIX_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;
    logic [RECIP_W-1:0] recip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            recip_reg  <= RECIP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[SIZE_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data[SIZE_W-1:0];
                CFG_RECIP_SCALE:  recip_reg  <= cfg_data[RECIP_W-1:0];
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: count every accepted transaction until it either
    // drops out without a result or leaves the result queue.
    // ------------------------------------------------------------------
    logic              accept;
    logic              pop;
    logic              push;
    logic              drop;
    logic [OCC_W-1:0]  occ_reg;
    logic [OCC_W-1:0]  occ_next;

    assign pix_stall = (occ_reg >= OCC_W'(OUT_DEPTH));
    assign accept    = pix_valid && !pix_stall;
    assign pop       = blur_valid && !blur_stall;
    assign occ_next  = occ_reg + OCC_W'(accept) - OCC_W'(drop) - OCC_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // ------------------------------------------------------------------
    // Raster position and effective image size
    // ------------------------------------------------------------------
    logic [AW-1:0]      col_reg;
    logic [COORD_W-1:0] row_reg;
    logic [AW-1:0]      col_next;
    logic [COORD_W-1:0] row_next;
    logic [EW-1:0]      w_eff;
    logic [SIZE_W-1:0]  h_eff;
    logic [EW-1:0]      col_ext;
    logic [EW-1:0]      col_inc;
    logic [SIZE_W-1:0]  row_inc;
    meta_t              meta0;

    always_comb
    begin
        // saturate the width to the line memory and the height to the row limit, treat zero as one
        w_eff = EW'(width_reg);
        if (w_eff > EW'(MAX_WIDTH))
        begin
            w_eff = EW'(MAX_WIDTH);
        end
        if (w_eff == '0)
        begin
            w_eff = EW'(1);
        end

        h_eff = height_reg;
        if (h_eff > ROW_LIMIT)
        begin
            h_eff = ROW_LIMIT;
        end
        if (h_eff == '0)
        begin
            h_eff = SIZE_W'(1);
        end
    end

    assign col_ext = EW'(col_reg);
    assign col_inc = col_ext + EW'(1);
    assign row_inc = SIZE_W'(row_reg) + SIZE_W'(1);

    always_comb
    begin
        if (col_inc >= w_eff)
        begin
            col_next = '0;
            row_next = (row_inc >= h_eff) ? '0 : row_inc[COORD_W-1:0];
        end
        else
        begin
            col_next = col_inc[AW-1:0];
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Window is full once both counts reach the window edge
    always_comb
    begin
        meta0.emit       = (SIZE_W'(row_reg) >= SIZE_W'(WINDOW - 1))
                        && (col_ext >= EW'(WINDOW - 1));
        meta0.center_row = row_reg - COORD_W'(HALF);
        meta0.center_col = COORD_W'(col_ext - EW'(HALF));
        meta0.frame_done = (SIZE_W'(row_reg) == h_eff - SIZE_W'(1))
                        && (col_ext == w_eff - EW'(1));
    end

    // ------------------------------------------------------------------
    // Stage 1: line memory data back, build the new column, write back
    // the rows shifted up by one.
    // ------------------------------------------------------------------
    logic              v1_reg;
    logic [PIX_W-1:0]  pix1_reg;
    logic [AW-1:0]     addr1_reg;
    logic              fwd1_reg;
    logic [WORD_W-1:0] fwd_word_reg;
    meta_t             meta1_reg;
    logic [WORD_W-1:0] rd_word;
    logic [WORD_W-1:0] rd_eff;
    logic [WORD_W-1:0] wr_word;
    logic              fwd_next;

    // A column revisited on the very next transaction (width of one) sees
    // the write still in flight; take it from the bypass instead.
    assign fwd_next = v1_reg && (addr1_reg == col_reg);
    assign rd_eff   = fwd1_reg ? fwd_word_reg : rd_word;

    if (LINES > 1)
    begin : g_shift_rows
        assign wr_word = {pix1_reg, rd_eff[WORD_W-1:PIX_W]};
    end
    else
    begin : g_one_row
        assign wr_word = pix1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix1_reg     <= {red, green, blue};
            addr1_reg    <= col_reg;
            fwd1_reg     <= fwd_next;
            fwd_word_reg <= wr_word;
            meta1_reg    <= meta0;
        end
    end

    rbb_line_store #(
        .WORD_W (WORD_W),
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (AW)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (v1_reg),
        .wr_addr (addr1_reg),
        .wr_data (wr_word),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (rd_word)
    );

    // ------------------------------------------------------------------
    // Channel lanes: oldest row first, incoming pixel last
    // ------------------------------------------------------------------
    logic [NUM_LANES-1:0][WINDOW-1:0][CHAN_W-1:0] lane_pix;
    logic [NUM_LANES-1:0][CHAN_W-1:0]             lane_blur;

    always_comb
    begin
        for (int ch = 0; ch < NUM_LANES; ch++)
        begin
            for (int r = 0; r < LINES; r++)
            begin
                lane_pix[ch][r] = rd_eff[r*PIX_W + ch*CHAN_W +: CHAN_W];
            end
            lane_pix[ch][LINES] = pix1_reg[ch*CHAN_W +: CHAN_W];
        end
    end

    for (genvar ch = 0; ch < NUM_LANES; ch++)
    begin : g_lane
        rbb_lane #(
            .WINDOW (WINDOW)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (v1_reg),
            .col_pix  (lane_pix[ch]),
            .recip    (recip_reg),
            .blur     (lane_blur[ch])
        );
    end

    // ------------------------------------------------------------------
    // Metadata follows the lanes: column sums, window sum, product, then merge
    // ------------------------------------------------------------------
    logic  v2_reg;
    logic  v3_reg;
    logic  v4_reg;
    meta_t meta2_reg;
    meta_t meta3_reg;
    meta_t meta4_reg;
    result_t merged;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        meta2_reg <= meta1_reg;
        meta3_reg <= meta2_reg;
        meta4_reg <= meta3_reg;
    end

    // queue only pixels whose window was full; drop the rest
    assign push = v4_reg && meta4_reg.emit;
    assign drop = v4_reg && !meta4_reg.emit;

    always_comb
    begin
        merged.blur_blue  = lane_blur[0];
        merged.blur_green = lane_blur[1];
        merged.blur_red   = lane_blur[2];
        merged.center_row = meta4_reg.center_row;
        merged.center_col = meta4_reg.center_col;
        merged.frame_done = meta4_reg.frame_done;
    end

    result_t head;

    rbb_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (merged),
        .pop        (pop),
        .head_valid (blur_valid),
        .head_data  (head)
    );

    assign blur_blue  = head.blur_blue;
    assign blur_green = head.blur_green;
    assign blur_red   = head.blur_red;
    assign center_row = head.center_row;
    assign center_col = head.center_col;
    assign frame_done = head.frame_done;

endmodule
